/* rtl/segment_panel_geometry_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the panel geometry block
// Clocked concurrent assertion helpers used by the port-level checker file.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_PANEL_GEOMETRY_MACROS_SVH
`define SEGMENT_PANEL_GEOMETRY_MACROS_SVH

// Assertion sampled on aclk, disabled while aresetn is low.
`define SPG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Assertion sampled on aclk that also holds during reset.
`define SPG_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* rtl/spg_pkg.sv */
// ----------------------------------------------------------------------------
// spg_pkg
// Shared widths, constants, tables and elaboration helpers for panel geometry.
// ----------------------------------------------------------------------------
package spg_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int TABLE_LEN         = 24;
    localparam int SQRT_STEPS        = 17;

    localparam int IN_W  = 64;
    localparam int OUT_W = 136;

    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [33:0] ANGLE_LIMIT = 34'sd25736;
    localparam logic signed [31:0] UNIT_Q14    = 32'sd16384;

    localparam logic signed [33:0] ATAN_Q30 [TABLE_LEN] = '{
        34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
        34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
        34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
        34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768,
        34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048,
        34'sd1024,      34'sd512,       34'sd256,       34'sd128
    };

    typedef struct packed {
        logic signed [15:0] mx;
        logic signed [15:0] my;
        logic signed [16:0] dx;
        logic signed [16:0] dy;
        logic               zero;
        logic               pre_pos;
        logic               pre_neg;
        logic        [33:0] dx2;
        logic        [33:0] dy2;
        logic        [34:0] v;
        logic        [34:0] r;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [33:0] z;
        logic signed [31:0] c;
        logic signed [31:0] s;
    } stage_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = '0;
        b = 64'h1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // 1/K in Q30 for n micro-rotations, long division by shift and subtract
    function automatic logic signed [31:0] inv_gain_q30(input int n);
        logic [63:0] p;
        logic [63:0] k;
        logic [63:0] num;
        logic [63:0] rem;
        logic [63:0] q;
        p = 64'h1 << 60;
        for (int i = 0; i < TABLE_LEN; i++) begin
            if (i < n) begin
                p = p + (p >> (2 * i));
            end
        end
        k   = isqrt64(p);
        num = (64'h1 << 60) + (k >> 1);
        rem = '0;
        q   = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= k) begin
                rem  = rem - k;
                q[b] = 1'b1;
            end
        end
        return q[31:0];
    endfunction

endpackage

/* rtl/segment_panel_geometry.sv */
// ----------------------------------------------------------------------------
// segment_panel_geometry
// Midpoint, length, angle, unit tangent and unit normal of one panel per beat.
// ----------------------------------------------------------------------------
// Input stream s_*: one beat per panel, tdata holds start_x, start_y, end_x,
// end_y (signed Q2.14). Output stream m_*: one beat per panel with mid_x,
// mid_y, panel_length (Q3.14), panel_angle (Q3.13 rad), tangent_x/y and
// normal_x/y (Q2.14), in input order.
// The pipeline is an input register, a square and pre-rotation stage, the
// work stages and an output register. The work stages run the CORDIC
// micro-rotations and, beside them, a bit-per-stage square root of dx^2 + dy^2
// (17 result bits). One panel enters each cycle unless the output stalls.
// The pipeline moves as a whole: when m_tvalid is high and m_tready low every
// stage holds and s_tready drops, so no beat is lost or repeated. Bubbles
// travel as empty stages with a cleared valid bit.
// Reset (aresetn low, synchronous) clears all valid bits; data registers keep
// their contents. A zero-length panel gives angle 0, tangent (1,0) and
// normal (0,1).
// ----------------------------------------------------------------------------
module segment_panel_geometry #(
    parameter int CORDIC_STAGES = spg_pkg::CORDIC_STAGES_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // start_x[15:0], start_y[31:16], end_x[47:32], end_y[63:48]
    input  logic [spg_pkg::IN_W-1:0]   s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // mid_x[15:0], mid_y[31:16], panel_length[48:32], panel_angle[64:49],
    // tangent_x[80:65], tangent_y[96:81], normal_x[112:97], normal_y[128:113],
    // zero pad [135:129]
    output logic [spg_pkg::OUT_W-1:0]  m_tdata
);
    import spg_pkg::*;

    localparam int N      = CORDIC_STAGES;
    localparam int P      = (N > SQRT_STEPS + 1) ? N : SQRT_STEPS + 1;
    localparam logic signed [31:0] INV_GAIN = inv_gain_q30(N);

    logic   adv;
    logic   vld_reg [P+2];
    stage_t st_reg  [P+2];
    stage_t st_a_next;
    stage_t st_b_next;
    logic   out_vld_reg;
    logic [OUT_W-1:0] out_reg;
    logic [OUT_W-1:0] out_next;

    assign adv      = !out_vld_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_reg;

    // stage A: differences and midpoint
    always_comb begin
        logic signed [15:0] sx, sy, ex, ey;
        logic signed [16:0] smx, smy;
        sx  = s_tdata[15:0];
        sy  = s_tdata[31:16];
        ex  = s_tdata[47:32];
        ey  = s_tdata[63:48];
        smx = 17'(sx) + 17'(ex);
        smy = 17'(sy) + 17'(ey);
        st_a_next      = '0;
        st_a_next.dx   = 17'(ex) - 17'(sx);
        st_a_next.dy   = 17'(ey) - 17'(sy);
        st_a_next.mx   = smx[16:1];
        st_a_next.my   = smy[16:1];
        st_a_next.zero = (ex == sx) && (ey == sy);
    end

    // stage B: squares and left half plane pre-rotation
    always_comb begin
        logic signed [33:0] pdx, pdy;
        logic signed [31:0] xs, ys;
        pdx = st_reg[0].dx * st_reg[0].dx;
        pdy = st_reg[0].dy * st_reg[0].dy;
        xs  = 32'(st_reg[0].dx) <<< 12;
        ys  = 32'(st_reg[0].dy) <<< 12;
        st_b_next     = st_reg[0];
        st_b_next.dx2 = pdx;
        st_b_next.dy2 = pdy;
        st_b_next.c   = INV_GAIN;
        st_b_next.s   = '0;
        st_b_next.pre_pos = 1'b0;
        st_b_next.pre_neg = 1'b0;
        if (xs < 0) begin
            if (ys >= 0) begin
                st_b_next.x = ys;
                st_b_next.y = -xs;
                st_b_next.z = HALF_PI_Q30;
                st_b_next.pre_pos = 1'b1;
            end else begin
                st_b_next.x = -ys;
                st_b_next.y = xs;
                st_b_next.z = -HALF_PI_Q30;
                st_b_next.pre_neg = 1'b1;
            end
        end else begin
            st_b_next.x = xs;
            st_b_next.y = ys;
            st_b_next.z = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
            vld_reg[1] <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= s_tvalid;
            vld_reg[1] <= vld_reg[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st_reg[0] <= st_a_next;
            st_reg[1] <= st_b_next;
        end
    end

    // work stages: up to one micro-rotation and one root bit per stage
    for (genvar j = 0; j < P; j++) begin : g_work
        stage_t st_next;

        always_comb begin
            stage_t cur;
            logic   up;
            cur     = st_reg[j+1];
            st_next = cur;
            up      = (cur.y >= 0);
            if (j < N) begin
                if (up) begin
                    st_next.x = cur.x + (cur.y >>> j);
                    st_next.y = cur.y - (cur.x >>> j);
                    st_next.z = cur.z + ATAN_Q30[(j < TABLE_LEN) ? j : 0];
                    st_next.c = cur.c - (cur.s >>> j);
                    st_next.s = cur.s + (cur.c >>> j);
                end else begin
                    st_next.x = cur.x - (cur.y >>> j);
                    st_next.y = cur.y + (cur.x >>> j);
                    st_next.z = cur.z - ATAN_Q30[(j < TABLE_LEN) ? j : 0];
                    st_next.c = cur.c + (cur.s >>> j);
                    st_next.s = cur.s - (cur.c >>> j);
                end
            end
            if (j == 0) begin
                st_next.v = 35'(cur.dx2) + 35'(cur.dy2);
                st_next.r = '0;
            end else if (j <= SQRT_STEPS) begin
                if (cur.v >= cur.r + (35'd1 << (2 * (SQRT_STEPS - j)))) begin
                    st_next.v = cur.v - (cur.r + (35'd1 << (2 * (SQRT_STEPS - j))));
                    st_next.r = (cur.r >> 1) + (35'd1 << (2 * (SQRT_STEPS - j)));
                end else begin
                    st_next.r = cur.r >> 1;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[j+2] <= 1'b0;
            end else if (adv) begin
                vld_reg[j+2] <= vld_reg[j+1];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                st_reg[j+2] <= st_next;
            end
        end
    end

    // output stage: rounding, clamping, special cases
    always_comb begin
        stage_t             f;
        logic        [34:0] len;
        logic signed [33:0] zr;
        logic signed [31:0] cc, ss, cr, sr, tx, ty;
        logic signed [15:0] ang;
        f   = st_reg[P+1];
        len = f.r + ((f.v > f.r) ? 35'd1 : 35'd0);
        zr  = (f.z + 34'sd65536) >>> 17;
        if (zr > ANGLE_LIMIT) begin
            ang = ANGLE_LIMIT[15:0];
        end else if (zr < -ANGLE_LIMIT) begin
            ang = 16'(-ANGLE_LIMIT);
        end else begin
            ang = zr[15:0];
        end
        if (f.pre_pos) begin
            cc = -f.s;
            ss = f.c;
        end else if (f.pre_neg) begin
            cc = f.s;
            ss = -f.c;
        end else begin
            cc = f.c;
            ss = f.s;
        end
        cr = (cc + 32'sd32768) >>> 16;
        sr = (ss + 32'sd32768) >>> 16;
        tx = (cr > UNIT_Q14) ? UNIT_Q14 : ((cr < -UNIT_Q14) ? -UNIT_Q14 : cr);
        ty = (sr > UNIT_Q14) ? UNIT_Q14 : ((sr < -UNIT_Q14) ? -UNIT_Q14 : sr);
        if (f.zero) begin
            ang = '0;
            tx  = UNIT_Q14;
            ty  = '0;
        end
        out_next          = '0;
        out_next[15:0]    = f.mx;
        out_next[31:16]   = f.my;
        out_next[48:32]   = len[16:0];
        out_next[64:49]   = ang;
        out_next[80:65]   = tx[15:0];
        out_next[96:81]   = ty[15:0];
        out_next[112:97]  = 16'(-ty);
        out_next[128:113] = tx[15:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            out_vld_reg <= vld_reg[P+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg <= out_next;
        end
    end

endmodule

/* rtl/segment_panel_geometry_checker.sv */
// ----------------------------------------------------------------------------
// segment_panel_geometry_checker
// Port-level checks on the panel geometry block, bound to segment_panel_geometry.
// ----------------------------------------------------------------------------
`include "segment_panel_geometry_macros.svh"

module segment_panel_geometry_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic [spg_pkg::IN_W-1:0]   s_tdata,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [spg_pkg::OUT_W-1:0]  m_tdata
);
    import spg_pkg::*;

    `SPG_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "output beat changed while stalled")
    `SPG_ASSERT(a_stall_back, m_tvalid && !m_tready |-> !s_tready, "input taken while output stalled")
    `SPG_ASSERT(a_empty_ready, !m_tvalid |-> s_tready, "input refused with empty output register")
    `SPG_ASSERT(a_normal_tan, m_tvalid |-> m_tdata[128:113] == m_tdata[80:65], "normal_y differs from tangent_x")
    `SPG_ASSERT_ALWAYS(a_reset_empty, $past(!aresetn) |-> !m_tvalid, "output valid right after reset")

endmodule

bind segment_panel_geometry segment_panel_geometry_checker u_spg_chk (.*);

/* dv/panel_geometry_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Panel geometry checker
// Watches both streams, predicts each panel result and compares whole result words.
// ----------------------------------------------------------------------------
module panel_geometry_checker #(
    parameter int CORDIC_STAGES = spg_pkg::CORDIC_STAGES_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [spg_pkg::IN_W-1:0]  s_tdata,
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [spg_pkg::OUT_W-1:0] m_tdata,
    output int                        fail_count,
    output int                        pending
);

    localparam longint ATAN_TAB [24] = '{
        843314857, 497837829, 263043837, 133525159, 67021687,
        33543516, 16775851, 8388437, 4194283, 2097149,
        1048576, 524288, 262144, 131072, 65536, 32768,
        16384, 8192, 4096, 2048, 1024, 512, 256, 128
    };
    localparam longint HALF_PI = 1686629713;

    logic [spg_pkg::OUT_W-1:0] result_fifo [$];

    function automatic longint shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint rshift(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint sat(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'h1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic logic [spg_pkg::OUT_W-1:0] panel_result(logic [63:0] d);
        longint sx, sy, ex, ey, dx, dy, mx, my, len, ang, tx, ty;
        longint x, y, z, t, c, s, xs, ys, cs, ss, kk;
        longint unsigned sq, p;
        int n, pre;
        bit up [24];
        logic [spg_pkg::OUT_W-1:0] r;
        sx = longint'($signed(d[15:0]));
        sy = longint'($signed(d[31:16]));
        ex = longint'($signed(d[47:32]));
        ey = longint'($signed(d[63:48]));
        dx = ex - sx;
        dy = ey - sy;
        mx = (sx + ex) >>> 1;
        my = (sy + ey) >>> 1;
        sq = dx * dx + dy * dy;
        len = int_sqrt(sq);
        if (sq - len * len > len) len = len + 1;
        pre = 0;
        if (dx == 0 && dy == 0) begin
            ang = 0;
            tx = 16384;
            ty = 0;
        end else begin
            n = CORDIC_STAGES < 1 ? 1 : (CORDIC_STAGES > 24 ? 24 : CORDIC_STAGES);
            x = dx * 4096;
            y = dy * 4096;
            z = 0;
            if (x < 0) begin
                t = x;
                if (y >= 0) begin
                    x = y; y = -t; z = HALF_PI; pre = 1;
                end else begin
                    x = -y; y = t; z = -HALF_PI; pre = -1;
                end
            end
            for (int i = 0; i < n; i++) begin
                xs = shr(x, i);
                ys = shr(y, i);
                up[i] = (y >= 0);
                if (up[i]) begin
                    x = x + ys; y = y - xs; z = z + ATAN_TAB[i];
                end else begin
                    x = x - ys; y = y + xs; z = z - ATAN_TAB[i];
                end
            end
            ang = sat(rshift(z, 17), 25736);
            p = 64'h1 << 60;
            for (int i = 0; i < n; i++) p = p + (p >> (2 * i));
            kk = int_sqrt(p);
            c = ((longint'(1) << 60) + kk / 2) / kk;
            s = 0;
            for (int i = 0; i < n; i++) begin
                cs = shr(c, i);
                ss = shr(s, i);
                if (up[i]) begin
                    c = c - ss; s = s + cs;
                end else begin
                    c = c + ss; s = s - cs;
                end
            end
            if (pre == 1) begin
                t = c; c = -s; s = t;
            end else if (pre == -1) begin
                t = c; c = s; s = -t;
            end
            tx = sat(rshift(c, 16), 16384);
            ty = sat(rshift(s, 16), 16384);
        end
        r = '0;
        r[15:0]    = mx[15:0];
        r[31:16]   = my[15:0];
        r[48:32]   = len[16:0];
        r[64:49]   = ang[15:0];
        r[80:65]   = tx[15:0];
        r[96:81]   = ty[15:0];
        r[112:97]  = 16'(-ty);
        r[128:113] = tx[15:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        logic [spg_pkg::OUT_W-1:0] want;
        if (!aresetn) begin
            fail_count <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                result_fifo.insert(result_fifo.size(), panel_result(s_tdata));
            end
            if (m_tvalid && m_tready) begin
                if (result_fifo.size() == 0) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10) $display("unexpected beat %h", m_tdata);
                end else begin
                    want = result_fifo.pop_front();
                    if (want !== m_tdata) begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10) begin
                            $display("mismatch: mid %h/%h len %h ang %h t %h/%h n %h/%h",
                                m_tdata[15:0], m_tdata[31:16], m_tdata[48:32],
                                m_tdata[64:49], m_tdata[80:65], m_tdata[96:81],
                                m_tdata[112:97], m_tdata[128:113]);
                            $display("  expected: mid %h/%h len %h ang %h t %h/%h n %h/%h",
                                want[15:0], want[31:16], want[48:32], want[64:49],
                                want[80:65], want[96:81], want[112:97], want[128:113]);
                        end
                    end
                end
            end
        end
        pending <= result_fifo.size();
    end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Panel geometry testbench
// Streams directed and random panels with random gaps and output stalls.
// ----------------------------------------------------------------------------
module testbench;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [spg_pkg::IN_W-1:0]  s_tdata = '0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [spg_pkg::OUT_W-1:0] m_tdata;
    int                        fail_count;
    int                        pending;
    bit                        calm = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    segment_panel_geometry dut (.*);

    panel_geometry_checker chk (.*);

    always @(posedge aclk) begin
        m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 22);
    end

    // send one beat, holding tvalid until accepted
    task automatic send_panel(logic [15:0] sx, logic [15:0] sy,
                              logic [15:0] ex, logic [15:0] ey);
        while (!calm && $urandom_range(99) < 22) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ey, ex, sy, sx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_coord();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(64)) - 16'd32;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic [15:0] a, b;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // extremes, zero length, axes and left half plane on both sides
        send_panel(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_panel(16'h1234, 16'h8000, 16'h1234, 16'h8000);
        send_panel(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
        send_panel(16'h7fff, 16'h7fff, 16'h8000, 16'h8000);
        send_panel(16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
        send_panel(16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
        send_panel(16'h0000, 16'h0000, 16'h4000, 16'h0000);
        send_panel(16'h0000, 16'h0000, 16'hc000, 16'h0000);
        send_panel(16'h0000, 16'h0000, 16'h0000, 16'h4000);
        send_panel(16'h0000, 16'h0000, 16'h0000, 16'hc000);
        send_panel(16'h0000, 16'h0000, 16'hffff, 16'h0000);
        send_panel(16'h0000, 16'h0000, 16'hffff, 16'hffff);
        send_panel(16'h0000, 16'h0000, 16'hffff, 16'h0001);
        send_panel(16'h0000, 16'h0000, 16'h0001, 16'hffff);
        send_panel(16'hffff, 16'hffff, 16'h0000, 16'h0000);
        send_panel(16'h0001, 16'h0000, 16'h0000, 16'h0000);
        send_panel(16'h7fff, 16'h0000, 16'h8000, 16'h0000);
        send_panel(16'h0000, 16'h7fff, 16'h0000, 16'h8000);
        // random panels, mostly contour-like chains
        a = 16'($urandom);
        b = 16'($urandom);
        for (int i = 0; i < 1700; i++) begin
            logic [15:0] na, nb;
            calm = (i >= 600 && i < 800);
            if ($urandom_range(3) == 0) begin
                send_panel(pick_coord(), pick_coord(), pick_coord(), pick_coord());
            end else begin
                na = a + 16'($urandom_range(2048)) - 16'd1024;
                nb = b + 16'($urandom_range(2048)) - 16'd1024;
                if ($urandom_range(19) == 0) na = a;
                if ($urandom_range(19) == 0) nb = b;
                send_panel(a, b, na, nb);
                a = na;
                b = nb;
            end
        end
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

/* segment_panel_geometry.f */
+incdir+rtl
rtl/spg_pkg.sv
rtl/segment_panel_geometry.sv
rtl/segment_panel_geometry_checker.sv
dv/panel_geometry_checker.sv
dv/testbench.sv
